[design/dpms_pkg.sv]
package dpms_pkg;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhEsc   = 2'd1,
    PhCsi   = 2'd2,
    PhParam = 2'd3
  } phase_e;

  localparam logic [7:0] EscByte   = 8'h1b;
  localparam logic [7:0] CsiByte   = 8'h5b;
  localparam logic [7:0] QmarkByte = 8'h3f;
  localparam logic [7:0] SemiByte  = 8'h3b;
  localparam logic [7:0] Digit0    = 8'h30;
  localparam logic [7:0] Digit9    = 8'h39;
  localparam logic [7:0] SetByte   = 8'h68;
  localparam logic [7:0] ResetByte = 8'h6c;

  localparam int unsigned AccW = 14;
  localparam logic [AccW-1:0] AccMax = 14'd16383;

  localparam logic [AccW-1:0] CodePaste    = 14'd2004;
  localparam logic [AccW-1:0] CodeX10      = 14'd9;
  localparam logic [AccW-1:0] CodeNormal   = 14'd1000;
  localparam logic [AccW-1:0] CodeButton   = 14'd1002;
  localparam logic [AccW-1:0] CodeAny      = 14'd1003;
  localparam logic [AccW-1:0] CodeUtf8     = 14'd1005;
  localparam logic [AccW-1:0] CodeSgr      = 14'd1006;
  localparam logic [AccW-1:0] CodeUrxvt    = 14'd1015;

  localparam logic [2:0] TrkNone   = 3'd0;
  localparam logic [2:0] TrkX10    = 3'd1;
  localparam logic [2:0] TrkNormal = 3'd2;
  localparam logic [2:0] TrkButton = 3'd3;
  localparam logic [2:0] TrkAny    = 3'd4;

  localparam logic [1:0] EncDefault = 2'd0;
  localparam logic [1:0] EncUtf8    = 2'd1;
  localparam logic [1:0] EncSgr     = 2'd2;
  localparam logic [1:0] EncUrxvt   = 2'd3;

  typedef struct packed {
    logic       done;
    logic [1:0] encoding;
    logic [2:0] tracking;
    logic       paste;
  } res_t;

  typedef struct packed {
    logic free;
    logic load;
  } flow_t;

endpackage

[design/dpms_in_stage.sv]
module dpms_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,
  input  dpms_pkg::flow_t flow_i,
  output logic            step_o,
  output logic [7:0]      byte_o
);
  import dpms_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign step_o          = valid_q && flow_i.free;
  assign s_axis_tready_o = !valid_q || step_o;
  assign byte_o          = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready_o) begin
      valid_d = s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i;
    end
  end

endmodule

[design/dpms_parser.sv]
module dpms_parser #(
  parameter int unsigned MaxParamChars = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  output dpms_pkg::res_t res_o
);
  import dpms_pkg::*;

  localparam int unsigned CntW = $clog2(MaxParamChars + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxParamChars);

  phase_e          phase_q, phase_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            sat_q, sat_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pst_seen_q, pst_seen_d;
  logic [2:0]      trk_code_q, trk_code_d;
  logic [1:0]      enc_code_q, enc_code_d;
  logic            paste_q, paste_d;
  logic [2:0]      trk_q, trk_d;
  logic [1:0]      enc_q, enc_d;
  logic            done;

  logic            fin_paste;
  logic [2:0]      fin_trk;
  logic [1:0]      fin_enc;
  logic [AccW+3:0] acc_next;
  logic            is_digit;
  logic            set_mode;

  assign is_digit = (byte_i >= Digit0) && (byte_i <= Digit9);
  assign set_mode = (byte_i == SetByte);
  assign acc_next = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0}
                  + (AccW+4)'(byte_i - Digit0);

  always_comb begin
    fin_paste = pst_seen_q;
    fin_trk   = trk_code_q;
    fin_enc   = enc_code_q;
    if (!sat_q) begin
      unique case (acc_q)
        CodePaste:  fin_paste = 1'b1;
        CodeX10:    fin_trk   = TrkX10;
        CodeNormal: fin_trk   = TrkNormal;
        CodeButton: fin_trk   = TrkButton;
        CodeAny:    fin_trk   = TrkAny;
        CodeUtf8:   fin_enc   = EncUtf8;
        CodeSgr:    fin_enc   = EncSgr;
        CodeUrxvt:  fin_enc   = EncUrxvt;
        default:    fin_paste = pst_seen_q;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    sat_d      = sat_q;
    cnt_d      = cnt_q;
    pst_seen_d = pst_seen_q;
    trk_code_d = trk_code_q;
    enc_code_d = enc_code_q;
    paste_d    = paste_q;
    trk_d      = trk_q;
    enc_d      = enc_q;
    done       = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (byte_i == EscByte) begin
          phase_d = PhEsc;
        end
      end
      PhEsc: begin
        phase_d = (byte_i == CsiByte) ? PhCsi : PhIdle;
      end
      PhCsi: begin
        if (byte_i == QmarkByte) begin
          phase_d    = PhParam;
          acc_d      = '0;
          sat_d      = 1'b0;
          cnt_d      = '0;
          pst_seen_d = 1'b0;
          trk_code_d = TrkNone;
          enc_code_d = EncDefault;
        end else begin
          phase_d = PhIdle;
        end
      end
      PhParam: begin
        priority if (set_mode || byte_i == ResetByte) begin
          if (fin_paste) begin
            paste_d = set_mode;
          end
          if (fin_trk != TrkNone) begin
            trk_d = set_mode ? fin_trk : TrkNone;
          end
          if (fin_enc != EncDefault) begin
            enc_d = set_mode ? fin_enc : EncDefault;
          end
          acc_d      = '0;
          sat_d      = 1'b0;
          cnt_d      = '0;
          pst_seen_d = 1'b0;
          trk_code_d = TrkNone;
          enc_code_d = EncDefault;
          phase_d    = PhIdle;
          done       = 1'b1;
        end else if (is_digit || byte_i == SemiByte) begin
          if (cnt_q < CntMax) begin
            cnt_d = cnt_q + 1'b1;
            if (byte_i == SemiByte) begin
              pst_seen_d = fin_paste;
              trk_code_d = fin_trk;
              enc_code_d = fin_enc;
              acc_d      = '0;
              sat_d      = 1'b0;
            end else if (!sat_q) begin
              if (acc_next > (AccW+4)'(AccMax)) begin
                sat_d = 1'b1;
              end else begin
                acc_d = acc_next[AccW-1:0];
              end
            end
          end
        end else if (byte_i == EscByte) begin
          phase_d = PhEsc;
        end else begin
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  assign res_o = '{done: done, encoding: enc_d, tracking: trk_d, paste: paste_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      acc_q      <= '0;
      sat_q      <= 1'b0;
      cnt_q      <= '0;
      pst_seen_q <= 1'b0;
      trk_code_q <= TrkNone;
      enc_code_q <= EncDefault;
      paste_q    <= 1'b0;
      trk_q      <= TrkNone;
      enc_q      <= EncDefault;
    end else if (step_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      sat_q      <= sat_d;
      cnt_q      <= cnt_d;
      pst_seen_q <= pst_seen_d;
      trk_code_q <= trk_code_d;
      enc_code_q <= enc_code_d;
      paste_q    <= paste_d;
      trk_q      <= trk_d;
      enc_q      <= enc_d;
    end
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done |=> phase_q == PhIdle && cnt_q == '0)
    else $error("sequence end did not return to idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("parameter count past limit");

  a_done_from_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done |-> phase_q == PhParam)
    else $error("sequence end outside parameters");

  a_trk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trk_q <= TrkAny && trk_code_q <= TrkAny)
    else $error("tracking level out of range");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(acc_q) && $stable(trk_q))
    else $error("state moved without an item");

endmodule

[design/dpms_out_stage.sv]
module dpms_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  dpms_pkg::res_t  res_i,
  output dpms_pkg::flow_t flow_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o
);
  import dpms_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign flow_o          = '{free: (!valid_q || m_axis_tready_i), load: step_i};
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {1'b0, res_q.done, res_q.encoding, res_q.tracking, res_q.paste};

  always_comb begin
    valid_d = valid_q;
    if (flow_o.load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_o.load) begin
      res_q <= res_i;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !m_axis_tready_i |-> !step_i)
    else $error("result overwritten while stalled");

endmodule

[design/dec_private_mode_sniffer.sv]
// DEC private mode sniffer.
// Input channel s_axis: one raw byte of terminal output per item.
// Output channel m_axis: exactly one result item per input byte, in order,
// carrying the mode state after that byte and a flag set when the byte was
// the final h or l of an ESC [ ? params sequence.
// The block scans at one byte per cycle while the receiver takes results. An
// accepted byte lands in the input register; when the result register is free,
// the parser updates its state and the result register takes the item at the
// same edge, which raises tvalid of that result. The parser state is a single
// register set updated once per byte. When the receiver stalls the result
// register holds its item; the input register still takes one more byte, then
// tready drops until the result is taken. Reset returns the parser to idle,
// clears all modes to zero (paste off, no tracking, default encoding) and
// empties both registers. Only the first MAX_PARAM_CHARS parameter
// characters of a sequence count.
module dec_private_mode_sniffer #(
  parameter int unsigned MAX_PARAM_CHARS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] byte_in
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] bracketed_paste, [3:1] mouse_tracking,
                                      // [5:4] mouse_encoding, [6] sequence_done, [7] zero
);
  import dpms_pkg::*;

  flow_t      flow;
  logic       step;
  logic [7:0] byte_cur;
  res_t       res;

  dpms_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .flow_i          (flow),
    .step_o          (step),
    .byte_o          (byte_cur)
  );

  dpms_parser #(
    .MaxParamChars (MAX_PARAM_CHARS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_cur),
    .res_o  (res)
  );

  dpms_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .res_i           (res),
    .flow_o          (flow),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
